FILE: sv/tmwf_pkg.sv
// Shared constants and types for the trimmed mean weight filter.
package tmwf_pkg;

	localparam int SAMPLE_IN_BITS = 16;
	localparam int WEIGHT_BITS    = 16;
	localparam int TARE_BITS      = 16;
	localparam int COUNT_BITS     = 4;
	// last sample index and right shift that averages the eight kept ones
	localparam logic [COUNT_BITS-1:0] BATCH_LAST = 4'd9;
	localparam int KEEP_SHIFT = 3;
	localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = 16'hFFFF;

	// stage control handed from the batch accumulator to the trim stage
	typedef struct packed {
		logic vld;     // a result leaves this stage
		logic missing; // batch aborted by an absent sensor
	} batch_ctrl_t;

endpackage

FILE: sv/tmwf_accum.sv
// Running sum, minimum, maximum and count of one batch; registers a finished batch.
module tmwf_accum #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_s1,
	input  logic [SAMPLE_BITS-1:0]       sample_s1,
	input  logic                         missing_s1,
	output tmwf_pkg::batch_ctrl_t        ctrl_s2,
	output logic [SAMPLE_BITS+3:0]       sum_s2,
	output logic [SAMPLE_BITS-1:0]       min_s2,
	output logic [SAMPLE_BITS-1:0]       max_s2
);

	localparam logic [SAMPLE_BITS-1:0] MIN_INIT = {SAMPLE_BITS{1'b1}};

	logic [tmwf_pkg::COUNT_BITS-1:0] count_q;
	logic [SAMPLE_BITS+3:0]          sum_q;
	logic [SAMPLE_BITS-1:0]          min_q;
	logic [SAMPLE_BITS-1:0]          max_q;

	logic [SAMPLE_BITS+3:0] sum_nxt;
	logic [SAMPLE_BITS-1:0] min_nxt;
	logic [SAMPLE_BITS-1:0] max_nxt;
	logic                   last;

	assign sum_nxt = sum_q + {4'd0, sample_s1};
	assign min_nxt = (sample_s1 < min_q) ? sample_s1 : min_q;
	assign max_nxt = (sample_s1 > max_q) ? sample_s1 : max_q;
	assign last    = (count_q == tmwf_pkg::BATCH_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= MIN_INIT;
			max_q   <= '0;
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2.vld     <= valid_s1 && (missing_s1 || last);
			ctrl_s2.missing <= valid_s1 && missing_s1;
			if (valid_s1) begin
				if (missing_s1 || last) begin
					count_q <= '0;
					sum_q   <= '0;
					min_q   <= MIN_INIT;
					max_q   <= '0;
				end else begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_nxt;
					min_q   <= min_nxt;
					max_q   <= max_nxt;
				end
			end
		end
	end

	// finished batch totals, including the tenth sample
	always_ff @(posedge clk) begin
		if (en && valid_s1 && last) begin
			sum_s2 <= sum_nxt;
			min_s2 <= min_nxt;
			max_s2 <= max_nxt;
		end
	end

endmodule

FILE: sv/tmwf_trim.sv
// Drops the extremes, averages, subtracts tare and clamps into the output register.
module tmwf_trim #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  tmwf_pkg::batch_ctrl_t              ctrl_s2,
	input  logic [SAMPLE_BITS+3:0]             sum_s2,
	input  logic [SAMPLE_BITS-1:0]             min_s2,
	input  logic [SAMPLE_BITS-1:0]             max_s2,
	input  logic [tmwf_pkg::TARE_BITS-1:0]     tare,
	output logic                               out_valid_q,
	output logic [tmwf_pkg::WEIGHT_BITS-1:0]   weight_q,
	output logic                               missing_q
);

	localparam int MEAN_BITS = SAMPLE_BITS + 4 - tmwf_pkg::KEEP_SHIFT;
	localparam int CMP_BITS  = (MEAN_BITS > tmwf_pkg::TARE_BITS) ? MEAN_BITS
	                                                            : tmwf_pkg::TARE_BITS;

	logic [SAMPLE_BITS+3:0]          trimmed;
	logic [MEAN_BITS-1:0]            mean;
	logic [CMP_BITS-1:0]             mean_c;
	logic [CMP_BITS-1:0]             tare_c;
	logic [CMP_BITS-1:0]             net;
	logic [tmwf_pkg::WEIGHT_BITS-1:0] weight;

	// sum always holds both extremes, so no underflow
	assign trimmed = sum_s2 - {4'd0, min_s2} - {4'd0, max_s2};
	assign mean    = trimmed[SAMPLE_BITS+3:tmwf_pkg::KEEP_SHIFT];
	assign mean_c  = CMP_BITS'(mean);
	assign tare_c  = CMP_BITS'(tare);
	assign net     = (mean_c > tare_c) ? (mean_c - tare_c) : '0;
	assign weight  = (net > CMP_BITS'(tmwf_pkg::WEIGHT_MAX)) ? tmwf_pkg::WEIGHT_MAX
	                                                          : net[tmwf_pkg::WEIGHT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctrl_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && ctrl_s2.vld) begin
			weight_q  <= ctrl_s2.missing ? '0 : weight;
			missing_q <= ctrl_s2.missing;
		end
	end

endmodule

FILE: sv/trimmed_mean_weight_filter_unit.sv
// Top level of the trimmed mean weight filter.
//
// Usage: load-cell samples arrive on the s_ stream, one per transfer. Each
// batch of ten good samples yields one result on the m_ stream: the mean of
// the eight middle samples minus the tare, clamped at zero and at 65535.
// Samples one to nine of a batch produce nothing. A sample flagged as
// sensor-missing (s_tuser) ends the batch at once and yields weight zero
// with the missing flag (m_tuser) set; the batch accumulators clear.
// The tare is written through tare_we / tare_wdata while the block is idle.
//
// Timing: a sample passes an input register, the accumulator stage and the
// output register, which shows the result of the sample that completes its
// batch. One sample is taken every cycle unless the output stalls; all
// three stages move together on a single enable.
// Stall: while a result waits in the output register and m_tready is low,
// the pipeline holds and s_tready drops; it rises again in the cycle the
// result is taken.
// Reset: arst_n clears the pipeline valids, the batch (count and sum zero,
// minimum all ones, maximum zero) and the tare.
module trimmed_mean_weight_filter_unit #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] raw_sample
	input  logic [0:0]  s_tuser,   // [0] sensor_missing
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] net_weight
	output logic [0:0]  m_tuser,   // [0] missing_flag
	input  logic        tare_we,
	input  logic [15:0] tare_wdata
);

	logic                   en;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   missing_s1;
	logic [tmwf_pkg::TARE_BITS-1:0] tare_q;

	logic [SAMPLE_BITS+tmwf_pkg::SAMPLE_IN_BITS-1:0] raw_ext;

	tmwf_pkg::batch_ctrl_t  ctrl_s2;
	logic [SAMPLE_BITS+3:0] sum_s2;
	logic [SAMPLE_BITS-1:0] min_s2;
	logic [SAMPLE_BITS-1:0] max_s2;

	logic [tmwf_pkg::WEIGHT_BITS-1:0] weight_q;
	logic                             missing_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	// zero-extend then keep the low SAMPLE_BITS bits
	assign raw_ext  = {{SAMPLE_BITS{1'b0}}, s_tdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_tvalid) begin
			sample_s1  <= raw_ext[SAMPLE_BITS-1:0];
			missing_s1 <= s_tuser[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tare_q <= '0;
		end else if (tare_we) begin
			tare_q <= tare_wdata;
		end
	end

	tmwf_accum #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.valid_s1   (valid_s1),
		.sample_s1  (sample_s1),
		.missing_s1 (missing_s1),
		.ctrl_s2    (ctrl_s2),
		.sum_s2     (sum_s2),
		.min_s2     (min_s2),
		.max_s2     (max_s2)
	);

	tmwf_trim #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_trim (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctrl_s2     (ctrl_s2),
		.sum_s2      (sum_s2),
		.min_s2      (min_s2),
		.max_s2      (max_s2),
		.tare        (tare_q),
		.out_valid_q (m_tvalid),
		.weight_q    (weight_q),
		.missing_q   (missing_q)
	);

	assign m_tdata = weight_q;
	assign m_tuser = missing_q;

	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("missing-sensor result carries a nonzero weight");

	a_missing_result: assert property (@(posedge clk) disable iff (!arst_n)
		en && valid_s1 && missing_s1 |=> ctrl_s2.vld && ctrl_s2.missing)
		else $error("missing-sensor sample did not end the batch");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		en && ctrl_s2.vld |=> m_tvalid && (m_tuser[0] == $past(ctrl_s2.missing)))
		else $error("finished batch did not reach the output register");

endmodule

FILE: verif/trimmed_mean_weight_filter_unit_test.sv
// Self-checking testbench for the trimmed mean weight filter: random batches vs. a local predictor.
module trimmed_mean_weight_filter_unit_test;

	localparam int IDLE_LIMIT = 2000;
	localparam int RX_HOLD    = 150;
	localparam int PHASE_ITEMS = 290;
	localparam int SUM_BITS   = tmwf_pkg::SAMPLE_IN_BITS + 4;

	typedef struct {
		logic [tmwf_pkg::SAMPLE_IN_BITS-1:0] raw;
		logic                                missing;
		int                                  gap;
	} sample_item_t;

	typedef struct {
		logic [tmwf_pkg::WEIGHT_BITS-1:0] net;
		logic                             missing;
	} weight_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] raw_sample
	logic [0:0]  s_tuser = '0;   // [0] sensor_missing
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] net_weight
	logic [0:0]  m_tuser;        // [0] missing_flag
	logic        tare_we = 1'b0;
	logic [15:0] tare_wdata = '0;

	// predictor state, mirrors the batch accumulators of the block
	logic [tmwf_pkg::COUNT_BITS-1:0]     acc_count = '0;
	logic [SUM_BITS-1:0]                 acc_sum = '0;
	logic [tmwf_pkg::SAMPLE_IN_BITS-1:0] acc_min = '1;
	logic [tmwf_pkg::SAMPLE_IN_BITS-1:0] acc_max = '0;
	logic [tmwf_pkg::TARE_BITS-1:0]      tare_now = '0;

	sample_item_t sample_q[$];
	weight_t      weight_q[$];

	bit in_fire = 1'b0;
	bit calm = 1'b0;
	bit rx_hold_req = 1'b0;
	int tx_wait = 0;
	int rx_gap = 0;
	int idle_cycles = 0;
	int errors = 0;

	trimmed_mean_weight_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.tare_we   (tare_we),
		.tare_wdata(tare_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones; none in calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void clear_batch();
		acc_count = '0;
		acc_sum = '0;
		acc_min = '1;
		acc_max = '0;
	endfunction

	// fold one accepted sample into the batch; queue the weight it yields, if any
	function automatic void absorb_sample(logic [tmwf_pkg::SAMPLE_IN_BITS-1:0] raw,
		logic missing);
		logic [SUM_BITS-1:0] mean;
		logic [SUM_BITS-1:0] net;
		weight_t w;
		if (missing) begin
			clear_batch();
			w.net = '0;
			w.missing = 1'b1;
			weight_q.push_back(w);
			return;
		end
		acc_sum = acc_sum + SUM_BITS'(raw);
		if (raw < acc_min)
			acc_min = raw;
		if (raw > acc_max)
			acc_max = raw;
		if (acc_count != tmwf_pkg::BATCH_LAST) begin
			acc_count = acc_count + 1'b1;
			return;
		end
		// both extremes are part of the sum, so no underflow here
		mean = (acc_sum - SUM_BITS'(acc_min) - SUM_BITS'(acc_max)) >> tmwf_pkg::KEEP_SHIFT;
		net = (mean > SUM_BITS'(tare_now)) ? mean - SUM_BITS'(tare_now) : '0;
		if (net > SUM_BITS'(tmwf_pkg::WEIGHT_MAX))
			net = SUM_BITS'(tmwf_pkg::WEIGHT_MAX);
		clear_batch();
		w.net = net[tmwf_pkg::WEIGHT_BITS-1:0];
		w.missing = 1'b0;
		weight_q.push_back(w);
	endfunction

	function automatic void push_item(logic [tmwf_pkg::SAMPLE_IN_BITS-1:0] raw,
		logic missing);
		sample_item_t it;
		it.raw = raw;
		it.missing = missing;
		it.gap = pick_gap();
		sample_q.push_back(it);
	endfunction

	// load-cell style reading: jitter around a base, with some outliers
	function automatic logic [tmwf_pkg::SAMPLE_IN_BITS-1:0] sample_near(
		logic [tmwf_pkg::SAMPLE_IN_BITS-1:0] base);
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 16'($urandom_range(0, 65535));
		if (r < 13)
			return '0;
		if (r < 16)
			return '1;
		v = int'(base) + int'($urandom_range(0, 400)) - 200;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return v[tmwf_pkg::SAMPLE_IN_BITS-1:0];
	endfunction

	// whole batches mostly; some aborted by a missing sensor, some stray missing samples
	task automatic queue_batches(int n);
		int cnt;
		int cut;
		logic [tmwf_pkg::SAMPLE_IN_BITS-1:0] base;
		cnt = 0;
		while (cnt < n) begin
			base = 16'($urandom_range(0, 65535));
			if ($urandom_range(0, 19) == 0) begin
				push_item(16'($urandom_range(0, 65535)), 1'b1);
				cnt++;
			end
			cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, tmwf_pkg::BATCH_LAST))
			                                  : int'(tmwf_pkg::BATCH_LAST) + 1;
			for (int k = 0; k < cut; k++)
				push_item(sample_near(base), 1'b0);
			cnt += cut;
			if (cut <= int'(tmwf_pkg::BATCH_LAST)) begin
				push_item(16'($urandom_range(0, 65535)), 1'b1);
				cnt++;
			end
		end
	endtask

	// waits until every queued sample is sent and every weight is back, then lets the pipeline empty
	task automatic drain_results(int tail);
		while (sample_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (weight_q.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_tare(logic [tmwf_pkg::TARE_BITS-1:0] value);
		@(negedge clk);
		tare_we <= 1'b1;
		tare_wdata <= value;
		tare_now = value;
		@(negedge clk);
		tare_we <= 1'b0;
	endtask

	// sender: next sample goes out once the previous transfer is done and its gap has passed
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (sample_q.size() != 0 && tx_wait >= sample_q[0].gap) begin
				s_tdata <= sample_q[0].raw;
				s_tuser <= sample_q[0].missing;
				s_tvalid <= 1'b1;
				void'(sample_q.pop_front());
				tx_wait = 0;
			end else begin
				s_tvalid <= 1'b0;
				if (sample_q.size() != 0)
					tx_wait++;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (rx_hold_req) begin
			rx_gap = RX_HOLD;
			rx_hold_req = 1'b0;
			m_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			rx_gap = pick_gap();
		end
	end

	// monitor: predict on input transfers, check on output transfers, watchdog
	always @(posedge clk) begin
		weight_t got;
		weight_t want;
		if (arst_n) begin
			in_fire = s_tvalid && s_tready;
			if (in_fire)
				absorb_sample(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready) begin
				got.net = m_tdata;
				got.missing = m_tuser[0];
				if (weight_q.size() == 0) begin
					$display("%0t: unexpected weight net=%h missing=%b",
						$time, got.net, got.missing);
					errors++;
				end else begin
					want = weight_q.pop_front();
					if (got.net !== want.net || got.missing !== want.missing) begin
						$display("%0t: weight mismatch expected net=%h missing=%b got net=%h missing=%b",
							$time, want.net, want.missing, got.net, got.missing);
						errors++;
					end
				end
			end
			if (in_fire || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [tmwf_pkg::TARE_BITS-1:0] phase_tare[6];
		phase_tare[0] = 16'hFFFF;
		phase_tare[1] = 16'h0000;
		phase_tare[2] = 16'($urandom_range(0, 65535));
		phase_tare[3] = 16'($urandom_range(0, 65535));
		phase_tare[4] = 16'h0001;
		phase_tare[5] = 16'($urandom_range(0, 65535));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_tare(16'h0000);
		// full-scale batch: zero and max are trimmed, the rest average to max
		push_item(16'h0000, 1'b0);
		repeat (9) push_item(16'hFFFF, 1'b0);
		// missing sensor on an empty batch, then in the middle of one
		push_item(16'h1234, 1'b1);
		push_item(16'h0001, 1'b0);
		push_item(16'h8000, 1'b0);
		push_item(16'h7FFF, 1'b0);
		push_item(16'hFFFF, 1'b1);
		drain_results(5);

		// tare equal to the mean gives zero
		write_tare(16'd1000);
		repeat (10) push_item(16'd1000, 1'b0);
		drain_results(5);

		for (int p = 0; p < 6; p++) begin
			write_tare(phase_tare[p]);
			calm = (p == 2);
			queue_batches(PHASE_ITEMS);
			if (p == 2)
				rx_hold_req = 1'b1;
			drain_results(5);
		end
		calm = 1'b0;
		drain_results(10);

		if (errors == 0 && weight_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
